/* design/imm_pkg.sv */
// Shared types, codes and defaults for the integer matrix multiplier.
package imm_pkg;

    // Default sizes
    localparam int MAX_DIM_DEF   = 8;
    localparam int ELEM_BITS_DEF = 16;

    // Fixed field widths
    localparam int VALUE_W = 16;
    localparam int SUM_W   = 35;
    localparam int DIM_W   = 4;
    localparam int POS_W   = 3;
    localparam int OP_W    = 2;
    localparam int CFG_IW  = 2;

    // Item operation codes
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IW-1:0] REG_ROWS_A    = 2'd0;
    localparam logic [CFG_IW-1:0] REG_INNER_DIM = 2'd1;
    localparam logic [CFG_IW-1:0] REG_COLS_B    = 2'd2;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // Per-MAC tag that travels with the operands
    typedef struct packed {
        logic             valid;
        logic             first;
        logic             lastk;
        logic             last;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } mac_tag_t;

    // Datapath status back to the sequencer
    typedef struct packed {
        logic adv;
        logic busy;
    } mac_stat_t;

endpackage

/* design/integer_matrix_multiply_top.sv */
// Top level of the signed integer matrix multiplier.
// Load items (write one element of A or B) are taken one per cycle while no run
// is in progress. A run item computes C = A x B through one shared multiplier
// and accumulator that do one multiply-accumulate per cycle unless a result
// waits untaken because m_ready is low; s_ready stays low for the whole run.
// Results leave in row-major order with m_last on the final entry. Elements must
// be loaded before a run reads them.
module integer_matrix_multiply_top
    import imm_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_we,
    input  logic [CFG_IW-1:0] cfg_index,
    input  logic [DIM_W-1:0]  cfg_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [OP_W-1:0]   s_op,
    input  logic [POS_W-1:0]  s_row,
    input  logic [POS_W-1:0]  s_col,
    input  logic [VALUE_W-1:0] s_value,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [POS_W-1:0]  m_out_row,
    output logic [POS_W-1:0]  m_out_col,
    output logic [SUM_W-1:0]  m_sum,
    output logic              m_last
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int VW    = (ELEM_BITS > VALUE_W) ? ELEM_BITS : VALUE_W;

    logic [DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;
    logic             accept, in_range, run_start, idle;
    logic             wr_a, wr_b;
    logic [AW-1:0]    wr_addr, a_addr, b_addr;
    logic signed [VW-1:0]  value_x;
    logic [ELEM_BITS-1:0]  elem;
    logic [ELEM_BITS-1:0]  a_data, b_data;
    mac_tag_t         issue;
    mac_stat_t        stat;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_a_reg    <= DIM_W'(8);
            inner_dim_reg <= DIM_W'(8);
            cols_b_reg    <= DIM_W'(8);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ROWS_A:    rows_a_reg    <= cfg_data;
                REG_INNER_DIM: inner_dim_reg <= cfg_data;
                REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Decode an accepted item
    assign s_ready   = idle;
    assign accept    = s_valid && s_ready;
    assign in_range  = (32'(s_row) < MAX_DIM) && (32'(s_col) < MAX_DIM);
    assign wr_a      = accept && (s_op == OP_LOAD_A) && in_range;
    assign wr_b      = accept && (s_op == OP_LOAD_B) && in_range;
    assign run_start = accept && (s_op == OP_RUN);
    assign wr_addr   = AW'(32'(s_row) * MAX_DIM + 32'(s_col));

    // Fit the loaded value to the element width
    assign value_x = VW'($signed(s_value));
    assign elem    = value_x[ELEM_BITS-1:0];

    imm_store #(
        .DEPTH (DEPTH),
        .W     (ELEM_BITS),
        .AW    (AW)
    ) u_a_store (
        .aclk    (aclk),
        .wr_en   (wr_a),
        .wr_addr (wr_addr),
        .wr_data (elem),
        .rd_en   (stat.adv),
        .rd_addr (a_addr),
        .rd_data (a_data)
    );

    imm_store #(
        .DEPTH (DEPTH),
        .W     (ELEM_BITS),
        .AW    (AW)
    ) u_b_store (
        .aclk    (aclk),
        .wr_en   (wr_b),
        .wr_addr (wr_addr),
        .wr_data (elem),
        .rd_en   (stat.adv),
        .rd_addr (b_addr),
        .rd_data (b_data)
    );

    imm_seq #(
        .MAX_DIM (MAX_DIM),
        .IW      (IW),
        .AW      (AW)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .run_start (run_start),
        .rows_a    (rows_a_reg),
        .inner_dim (inner_dim_reg),
        .cols_b    (cols_b_reg),
        .stat      (stat),
        .idle      (idle),
        .a_addr    (a_addr),
        .b_addr    (b_addr),
        .issue     (issue)
    );

    imm_mac #(
        .ELEM_BITS (ELEM_BITS)
    ) u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .a_data    (a_data),
        .b_data    (b_data),
        .stat      (stat),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_out_row (m_out_row),
        .m_out_col (m_out_col),
        .m_sum     (m_sum),
        .m_last    (m_last)
    );

endmodule

/* design/imm_store.sv */
// Element store: one write port and one registered read port.
module imm_store
    import imm_pkg::*;
#(
    parameter int DEPTH = MAX_DIM_DEF * MAX_DIM_DEF,
    parameter int W     = ELEM_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0]  wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0]  rd_data
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rd_data_reg;

    // Write a loaded element
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one operand, hold while stalled
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/imm_seq.sv */
// Run sequencer: walks i, j, k and issues one operand pair per cycle while the datapath advances.
module imm_seq
    import imm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF,
    parameter int IW      = $clog2(MAX_DIM),
    parameter int AW      = $clog2(MAX_DIM * MAX_DIM)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             run_start,
    input  logic [DIM_W-1:0] rows_a,
    input  logic [DIM_W-1:0] inner_dim,
    input  logic [DIM_W-1:0] cols_b,
    input  mac_stat_t        stat,
    output logic             idle,
    output logic [AW-1:0]    a_addr,
    output logic [AW-1:0]    b_addr,
    output mac_tag_t         issue
);

    state_t state_reg, state_next;

    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic [IW-1:0] ni_reg, ni_next;
    logic [IW-1:0] nj_reg, nj_next;
    logic [IW-1:0] nk_reg, nk_next;

    logic i_end, j_end, k_end, issuing;

    // Clamp a dimension register to 1..MAX_DIM and return count minus one
    function automatic logic [IW-1:0] dim_lim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] t;
        if (d == '0) begin
            t = '0;
        end else if (32'(d) > MAX_DIM) begin
            t = DIM_W'(MAX_DIM - 1);
        end else begin
            t = d - 1'b1;
        end
        return t[IW-1:0];
    endfunction

    assign i_end   = (i_reg == ni_reg);
    assign j_end   = (j_reg == nj_reg);
    assign k_end   = (k_reg == nk_reg);
    assign issuing = (state_reg == ST_RUN) && stat.adv;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (run_start) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (issuing && i_end && j_end && k_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!stat.busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Counters and latched limits
    always_comb begin
        i_next  = i_reg;
        j_next  = j_reg;
        k_next  = k_reg;
        ni_next = ni_reg;
        nj_next = nj_reg;
        nk_next = nk_reg;
        case (state_reg)
            ST_IDLE: begin
                if (run_start) begin
                    i_next  = '0;
                    j_next  = '0;
                    k_next  = '0;
                    ni_next = dim_lim(rows_a);
                    nj_next = dim_lim(cols_b);
                    nk_next = dim_lim(inner_dim);
                end
            end
            ST_RUN: begin
                if (issuing) begin
                    if (!k_end) begin
                        k_next = k_reg + 1'b1;
                    end else begin
                        k_next = '0;
                        if (!j_end) begin
                            j_next = j_reg + 1'b1;
                        end else begin
                            j_next = '0;
                            i_next = i_reg + 1'b1;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Issue outputs
    always_comb begin
        idle        = (state_reg == ST_IDLE);
        a_addr      = AW'(32'(i_reg) * MAX_DIM + 32'(k_reg));
        b_addr      = AW'(32'(k_reg) * MAX_DIM + 32'(j_reg));
        issue.valid = (state_reg == ST_RUN);
        issue.first = (k_reg == '0);
        issue.lastk = k_end;
        issue.last  = i_end && j_end;
        issue.row   = POS_W'(i_reg);
        issue.col   = POS_W'(j_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        i_reg  <= i_next;
        j_reg  <= j_next;
        k_reg  <= k_next;
        ni_reg <= ni_next;
        nj_reg <= nj_next;
        nk_reg <= nk_next;
    end

endmodule

/* design/imm_mac.sv */
// Shared multiply-accumulate unit with its result register.
module imm_mac
    import imm_pkg::*;
#(
    parameter int ELEM_BITS = ELEM_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mac_tag_t             issue,
    input  logic [ELEM_BITS-1:0] a_data,
    input  logic [ELEM_BITS-1:0] b_data,
    output mac_stat_t            stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [POS_W-1:0]     m_out_row,
    output logic [POS_W-1:0]     m_out_col,
    output logic [SUM_W-1:0]     m_sum,
    output logic                 m_last
);

    localparam int PW = 2 * ELEM_BITS;
    localparam int XW = (PW > SUM_W) ? PW : SUM_W;

    mac_tag_t s1_reg, s2_reg;
    logic signed [PW-1:0] prod_reg;
    logic signed [XW-1:0] prod_x;
    logic [SUM_W-1:0]     acc_reg, acc_next;
    logic                 out_valid_reg;
    logic [POS_W-1:0]     out_row_reg, out_col_reg;
    logic [SUM_W-1:0]     out_sum_reg;
    logic                 out_last_reg;
    logic                 adv;

    // Advance the whole pipe unless a result waits untaken
    assign adv = !out_valid_reg || m_ready;

    // Extend or wrap the product to the sum width and accumulate
    assign prod_x   = XW'(prod_reg);
    assign acc_next = (s2_reg.first ? '0 : acc_reg) + prod_x[SUM_W-1:0];

    // Tag stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
            s2_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_reg.valid <= issue.valid;
            s2_reg.valid <= s1_reg.valid;
        end
        if (adv) begin
            s1_reg.first <= issue.first;
            s1_reg.lastk <= issue.lastk;
            s1_reg.last  <= issue.last;
            s1_reg.row   <= issue.row;
            s1_reg.col   <= issue.col;
            s2_reg.first <= s1_reg.first;
            s2_reg.lastk <= s1_reg.lastk;
            s2_reg.last  <= s1_reg.last;
            s2_reg.row   <= s1_reg.row;
            s2_reg.col   <= s1_reg.col;
        end
    end

    // Multiply and accumulate
    always_ff @(posedge aclk) begin
        if (adv) begin
            prod_reg <= $signed(a_data) * $signed(b_data);
            if (s2_reg.valid) begin
                acc_reg <= acc_next;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && s2_reg.valid && s2_reg.lastk) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (adv && s2_reg.valid && s2_reg.lastk) begin
            out_row_reg  <= s2_reg.row;
            out_col_reg  <= s2_reg.col;
            out_sum_reg  <= acc_next;
            out_last_reg <= s2_reg.last;
        end
    end

    assign stat.adv  = adv;
    assign stat.busy = s1_reg.valid || s2_reg.valid || out_valid_reg;

    assign m_valid   = out_valid_reg;
    assign m_out_row = out_row_reg;
    assign m_out_col = out_col_reg;
    assign m_sum     = out_sum_reg;
    assign m_last    = out_last_reg;

endmodule
